/* src/modbus_rtu_frame_crc_defines.svh */
// Assertion helpers for the Modbus RTU frame CRC block.
`ifndef MODBUS_RTU_FRAME_CRC_DEFINES_SVH
`define MODBUS_RTU_FRAME_CRC_DEFINES_SVH

`ifndef SYNTHESIS
`define MRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* src/mrc_pkg.sv */
`default_nettype none

package mrc_pkg;

  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_SEED  = 16'hFFFF;
  localparam logic [8:0]  COUNT_MAX = 9'd511;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Configuration register indexes
  localparam logic REG_MODE     = 1'b0;
  localparam logic REG_PDU_SIZE = 1'b1;

  localparam logic MODE_BUILD = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_BAD_CRC   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_BIG   = 3'd4,
    ST_TOO_SMALL = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    status_e    status;
    logic [8:0] fsize;
  } result_t;

  // Up to three results pushed by one byte
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } push_t;

endpackage

`default_nettype wire

/* src/modbus_rtu_frame_crc.sv */
`default_nettype none

// Modbus RTU frame CRC (reflected CRC-16, polynomial 0xA001, seed 0xFFFF).
// Feed one byte per transfer, address first, last_byte_i on the final byte.
// Mode 0 echoes every byte and appends CRC low then high byte on the last one,
// with status and frame size on that final result; mode 1 gives one status
// result per frame. A byte is taken every cycle while the result queue has room
// for a three-result burst; a build-mode last byte yields three results and holds
// off input until the four-entry result queue, which drains one result per cycle
// while out_ready_i is high, has room again. A result passes the input register,
// then the result queue, before it is offered. Write mode and pdu_size only
// between frames with the block drained.
module modbus_rtu_frame_crc #(
  parameter int MAX_SIZE = 256,
  parameter int MIN_SIZE = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,

  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i,

  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,

  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic [2:0]      status_o,
  output logic [8:0]      frame_size_o
);

  logic       mode_q;
  logic [7:0] pdu_size_q;

  logic       s_valid_q;
  logic [7:0] s_byte_q;
  logic       s_last_q;

  logic             room;
  logic             adv;
  mrc_pkg::push_t   push;
  mrc_pkg::result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= mrc_pkg::MODE_BUILD;
      pdu_size_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mrc_pkg::REG_MODE:     mode_q     <= cfg_data_i[0];
        mrc_pkg::REG_PDU_SIZE: pdu_size_q <= cfg_data_i;
      endcase
    end
  end

  // Input register moves into the frame logic when the queue can take a burst
  assign adv        = s_valid_q && room;
  assign in_ready_o = !s_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s_byte_q <= data_byte_i;
      s_last_q <= last_byte_i;
    end
  end

  mrc_frame #(
    .MAX_SIZE (MAX_SIZE),
    .MIN_SIZE (MIN_SIZE)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (adv),
    .data_i     (s_byte_q),
    .last_i     (s_last_q),
    .mode_i     (mode_q),
    .pdu_size_i (pdu_size_q),
    .push_o     (push)
  );

  mrc_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  assign out_byte_o   = res.data;
  assign out_last_o   = res.last;
  assign status_o     = res.status;
  assign frame_size_o = res.fsize;

endmodule

`default_nettype wire

/* src/mrc_crc_unit.sv */
`default_nettype none

// One byte of reflected CRC-16, all eight bit steps unrolled.
module mrc_crc_unit (
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  data_i,
  output logic      [15:0] crc_o
);

  logic [15:0] c;

  always_comb begin
    c = crc_i ^ {8'h00, data_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mrc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

/* src/mrc_frame.sv */
`default_nettype none

// Per-frame state (count, running and captured CRC) and result generation.
module mrc_frame #(
  parameter int MAX_SIZE = 256,
  parameter int MIN_SIZE = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire logic [7:0]          data_i,
  input  wire logic                last_i,
  input  wire logic                mode_i,
  input  wire logic [7:0]          pdu_size_i,
  output mrc_pkg::push_t           push_o
);

  logic [8:0]  count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] cap_q, cap_d;

  logic [15:0] crc_new;
  logic [8:0]  n;
  logic [8:0]  adu;
  logic        hit;
  logic [15:0] cap_eff;
  logic [9:0]  ext;
  mrc_pkg::status_e st_build, st_check;
  logic [8:0]  fsize;

  mrc_crc_unit u_crc (
    .crc_i  (crc_q),
    .data_i (data_i),
    .crc_o  (crc_new)
  );

  assign n       = (count_q == mrc_pkg::COUNT_MAX) ? count_q : count_q + 9'd1;
  assign adu     = {1'b0, pdu_size_i} + 9'd3;
  assign hit     = (n == adu);
  assign cap_eff = hit ? crc_new : cap_q;
  assign ext     = {1'b0, n} + 10'd2;

  always_comb begin
    fsize = '0;
    if (n == 9'd1) begin
      st_build = mrc_pkg::ST_EMPTY;
    end else if (ext > 10'(MAX_SIZE)) begin
      st_build = mrc_pkg::ST_TOO_BIG;
    end else if (ext < 10'(MIN_SIZE)) begin
      st_build = mrc_pkg::ST_TOO_SMALL;
    end else begin
      st_build = mrc_pkg::ST_OK;
      fsize    = ext[8:0];
    end

    if ((n < 9'(MIN_SIZE)) || (n < adu)) begin
      st_check = mrc_pkg::ST_BAD_SIZE;
    end else if (cap_eff != 16'h0000) begin
      st_check = mrc_pkg::ST_BAD_CRC;
    end else begin
      st_check = mrc_pkg::ST_OK;
    end
  end

  always_comb begin
    push_o = '0;
    if (fire_i) begin
      if (mode_i == mrc_pkg::MODE_BUILD) begin
        push_o.res[0] = '{data: data_i, last: 1'b0, status: mrc_pkg::ST_OK, fsize: 9'd0};
        if (last_i) begin
          push_o.count  = 2'd3;
          push_o.res[1] = '{data: crc_new[7:0], last: 1'b0, status: mrc_pkg::ST_OK,
                            fsize: 9'd0};
          push_o.res[2] = '{data: crc_new[15:8], last: 1'b1, status: st_build,
                            fsize: fsize};
        end else begin
          push_o.count = 2'd1;
        end
      end else if (last_i) begin
        push_o.count  = 2'd1;
        push_o.res[0] = '{data: 8'h00, last: 1'b1, status: st_check, fsize: 9'd0};
      end
    end
  end

  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    cap_d   = cap_q;
    if (fire_i) begin
      if (last_i) begin
        count_d = '0;
        crc_d   = mrc_pkg::CRC_SEED;
        cap_d   = '0;
      end else begin
        count_d = n;
        crc_d   = crc_new;
        cap_d   = cap_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= mrc_pkg::CRC_SEED;
      cap_q   <= '0;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
      cap_q   <= cap_d;
    end
  end

endmodule

`default_nettype wire

/* src/mrc_out_queue.sv */
`default_nettype none

`include "modbus_rtu_frame_crc_defines.svh"

// Four-entry result queue: takes up to three results a cycle, hands out one while out_ready_i is high.
module mrc_out_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mrc_pkg::push_t    push_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output mrc_pkg::result_t       out_res_o
);

  mrc_pkg::result_t entries_q [mrc_pkg::QDEPTH];

  logic [mrc_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [mrc_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [mrc_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                       pop;

  // Room for a full three-result burst
  assign room_o      = (cnt_q <= mrc_pkg::QCNT_W'(mrc_pkg::QDEPTH - 3));
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = entries_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + mrc_pkg::QPTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + mrc_pkg::QPTR_W'(pop);
    cnt_d    = cnt_q + mrc_pkg::QCNT_W'(push_i.count) - mrc_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_i.count) begin
        entries_q[wr_ptr_q + mrc_pkg::QPTR_W'(k)] <= push_i.res[k];
      end
    end
  end

  `MRC_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= mrc_pkg::QCNT_W'(mrc_pkg::QDEPTH))
  `MRC_ASSERT_IMP(a_push_room, clk_i, rst_ni, push_i.count != 2'd0, room_o)
  `MRC_ASSERT_NXT(a_pop_drains, clk_i, rst_ni, pop && (push_i.count == 2'd0), cnt_q == $past(cnt_q) - 3'd1)

endmodule

`default_nettype wire
